[rtl/ntpsrb_pkg.sv]
// ----------------------------------------------------------------------------
// ntpsrb_pkg
// Shared types and constants of the NTP server response builder.
// ----------------------------------------------------------------------------
package ntpsrb_pkg;

	localparam int PKT_LEN   = 48;
	localparam int IDX_W     = 6;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 32;
	localparam int JOB_DEPTH = 2;
	localparam int JOB_PTR_W = 1;
	localparam int JOB_CNT_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_STRATUM = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_REF_ID  = 1'b1;

	localparam logic [7:0]  STRATUM_RST = 8'd1;
	localparam logic [31:0] REF_ID_RST  = 32'h4C4F434C;

	// association modes
	localparam logic [2:0] MODE_SYM_ACTIVE  = 3'd1;
	localparam logic [2:0] MODE_SYM_PASSIVE = 3'd2;
	localparam logic [2:0] MODE_CLIENT      = 3'd3;
	localparam logic [2:0] MODE_SERVER      = 3'd4;

	localparam logic [7:0]  PRECISION   = 8'hFA;
	localparam logic [31:0] ROOT_DISP   = 32'h00010000;
	localparam logic [31:0] UNIX_TO_NTP = 32'd2208988800;
	localparam logic [9:0]  MS_PER_SEC  = 10'd1000;

	// fraction = ms * 4294967 + floor(ms * 37 / 125)
	// and x / 125 = (x * 67109) >> 23 for x below 2^16
	localparam logic [22:0] FRAC_INT    = 23'd4294967;
	localparam logic [5:0]  FRAC_REM    = 6'd37;
	localparam logic [16:0] RECIP_125   = 17'd67109;
	localparam int          RECIP_SHIFT = 23;

	typedef struct packed {
		logic [2:0]  version;
		logic [2:0]  resp_mode;
		logic [7:0]  poll;
		logic [63:0] origin;
		logic [31:0] ntp_secs;
		logic [9:0]  millis;
	} job_t;

	typedef struct packed {
		logic [7:0]  stratum;
		logic [31:0] reference_id;
	} cfg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_status_t;

	typedef struct packed {
		logic             busy;
		logic [IDX_W-1:0] idx;
	} back_status_t;

endpackage

[rtl/ntpsrb_req_if.sv]
// ----------------------------------------------------------------------------
// ntpsrb_req_if
// Request byte channel: valid/ready with one request byte and the time.
// ----------------------------------------------------------------------------
interface ntpsrb_req_if;
	logic        valid;
	logic        ready;
	logic [7:0]  req_byte;
	logic        req_last;
	logic [31:0] now_unix_secs;
	logic [9:0]  now_millis;

	modport source (output valid, req_byte, req_last, now_unix_secs, now_millis,
		input ready);
	modport sink (input valid, req_byte, req_last, now_unix_secs, now_millis,
		output ready);
endinterface

[rtl/ntpsrb_resp_if.sv]
// ----------------------------------------------------------------------------
// ntpsrb_resp_if
// Reply byte channel: valid/ready with one reply byte.
// ----------------------------------------------------------------------------
interface ntpsrb_resp_if;
	logic       valid;
	logic       ready;
	logic [7:0] resp_byte;
	logic       resp_last;

	modport source (output valid, resp_byte, resp_last, input ready);
	modport sink (input valid, resp_byte, resp_last, output ready);
endinterface

[rtl/ntpsrb_front.sv]
// ----------------------------------------------------------------------------
// ntpsrb_front
// Parses request bytes and queues a reply job when a request qualifies.
// ----------------------------------------------------------------------------
module ntpsrb_front (
	input  logic                clk,
	input  logic                arst_n,
	ntpsrb_req_if.sink          req,
	input  logic                job_full,
	output logic                job_push,
	output ntpsrb_pkg::job_t    job
);

	logic [ntpsrb_pkg::IDX_W-1:0] cnt_q;
	logic [2:0]                   version_q;
	logic [2:0]                   mode_q;
	logic [7:0]                   poll_q;
	logic [63:0]                  origin_q;
	logic                         accept;
	logic                         pkt_full;
	logic                         mode_ok;
	logic [9:0]                   ms_mod;

	assign req.ready = !job_full;
	assign accept    = req.valid && req.ready;

	// at least 48 bytes once this byte is counted
	assign pkt_full = (cnt_q >= ntpsrb_pkg::IDX_W'(ntpsrb_pkg::PKT_LEN - 1));
	assign mode_ok  = (mode_q == ntpsrb_pkg::MODE_CLIENT) ||
		(mode_q == ntpsrb_pkg::MODE_SYM_ACTIVE);
	assign ms_mod   = (req.now_millis >= ntpsrb_pkg::MS_PER_SEC) ?
		req.now_millis - ntpsrb_pkg::MS_PER_SEC : req.now_millis;

	assign job_push = accept && req.req_last && pkt_full &&
		(req.now_unix_secs != 32'd0) && mode_ok;

	always_comb begin
		job.version    = version_q;
		job.resp_mode  = (mode_q == ntpsrb_pkg::MODE_CLIENT) ?
			ntpsrb_pkg::MODE_SERVER : ntpsrb_pkg::MODE_SYM_PASSIVE;
		job.poll       = poll_q;
		job.origin     = (cnt_q == ntpsrb_pkg::IDX_W'(ntpsrb_pkg::PKT_LEN - 1)) ?
			{origin_q[55:0], req.req_byte} : origin_q;
		job.ntp_secs   = req.now_unix_secs + ntpsrb_pkg::UNIX_TO_NTP;
		job.millis     = ms_mod;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			version_q <= '0;
			mode_q    <= '0;
			poll_q    <= '0;
			origin_q  <= '0;
		end else if (accept) begin
			if (cnt_q == '0) begin
				version_q <= req.req_byte[5:3];
				mode_q    <= req.req_byte[2:0];
			end
			if (cnt_q == ntpsrb_pkg::IDX_W'(2))
				poll_q <= req.req_byte;
			if (cnt_q >= ntpsrb_pkg::IDX_W'(40) &&
				cnt_q < ntpsrb_pkg::IDX_W'(ntpsrb_pkg::PKT_LEN))
				origin_q <= {origin_q[55:0], req.req_byte};
			// restart at every request end, saturate on long requests
			if (req.req_last)
				cnt_q <= '0;
			else if (cnt_q < ntpsrb_pkg::IDX_W'(ntpsrb_pkg::PKT_LEN))
				cnt_q <= cnt_q + 1'b1;
		end
	end

endmodule

[rtl/ntpsrb_fifo.sv]
// ----------------------------------------------------------------------------
// ntpsrb_fifo
// Two-entry job queue between the request parser and the reply serializer.
// ----------------------------------------------------------------------------
module ntpsrb_fifo (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  ntpsrb_pkg::job_t          wr_job,
	input  logic                      pop,
	output ntpsrb_pkg::job_t          rd_job,
	output ntpsrb_pkg::fifo_status_t  status
);

	ntpsrb_pkg::job_t                 entry_q [ntpsrb_pkg::JOB_DEPTH];
	logic [ntpsrb_pkg::JOB_PTR_W-1:0] wr_ptr_q;
	logic [ntpsrb_pkg::JOB_PTR_W-1:0] rd_ptr_q;
	logic [ntpsrb_pkg::JOB_CNT_W-1:0] cnt_q;

	assign status.full  = (cnt_q == ntpsrb_pkg::JOB_CNT_W'(ntpsrb_pkg::JOB_DEPTH));
	assign status.empty = (cnt_q == '0);
	assign rd_job       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

[rtl/ntpsrb_back.sv]
// ----------------------------------------------------------------------------
// ntpsrb_back
// Serializes one queued job into the 48-byte reply, one byte per transfer.
// ----------------------------------------------------------------------------
module ntpsrb_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ntpsrb_pkg::cfg_t          cfg,
	input  logic                      job_valid,
	input  ntpsrb_pkg::job_t          job,
	output logic                      job_pop,
	output ntpsrb_pkg::back_status_t  status,
	ntpsrb_resp_if.source             resp
);

	ntpsrb_pkg::job_t             cur_q;
	logic                         busy_q;
	logic [ntpsrb_pkg::IDX_W-1:0] idx_q;
	logic                         out_valid_q;
	logic [7:0]                   out_byte_q;
	logic                         out_last_q;

	logic [15:0]                  rem_s1;
	logic [8:0]                   rem_s2;
	logic [31:0]                  int_s2;
	logic [31:0]                  frac_s3;
	logic [32:0]                  rem_prod;

	logic                         advance;
	logic                         emit;
	logic                         last_byte;
	logic [31:0]                  word;
	logic [7:0]                   sel_byte;

	assign advance   = !out_valid_q || resp.ready;
	assign emit      = busy_q && advance;
	assign last_byte = (idx_q == ntpsrb_pkg::IDX_W'(ntpsrb_pkg::PKT_LEN - 1));
	assign job_pop   = job_valid && (!busy_q || (emit && last_byte));

	assign status.busy = busy_q;
	assign status.idx  = idx_q;

	assign resp.valid     = out_valid_q;
	assign resp.resp_byte = out_byte_q;
	assign resp.resp_last = out_last_q;

	// fraction settles through rem_s1, rem_s2 and frac_s3 after a job loads, long before byte 20
	assign rem_prod = {17'd0, rem_s1} * {16'd0, ntpsrb_pkg::RECIP_125};

	always_ff @(posedge clk) begin
		rem_s1  <= {6'd0, cur_q.millis} * {10'd0, ntpsrb_pkg::FRAC_REM};
		rem_s2  <= 9'(rem_prod >> ntpsrb_pkg::RECIP_SHIFT);
		int_s2  <= {22'd0, cur_q.millis} * {9'd0, ntpsrb_pkg::FRAC_INT};
		frac_s3 <= int_s2 + {23'd0, rem_s2};
	end

	always_comb begin
		case (idx_q[5:2]) inside
			4'd0:             word = {2'b00, cur_q.version, cur_q.resp_mode,
				cfg.stratum, cur_q.poll, ntpsrb_pkg::PRECISION};
			4'd2:             word = (cfg.stratum != 8'd1) ? ntpsrb_pkg::ROOT_DISP : 32'd0;
			4'd3:             word = cfg.reference_id;
			4'd4, 4'd8, 4'd10: word = cur_q.ntp_secs;
			4'd5, 4'd9, 4'd11: word = frac_s3;
			4'd6:             word = cur_q.origin[63:32];
			4'd7:             word = cur_q.origin[31:0];
			default:          word = 32'd0;
		endcase
	end

	always_comb begin
		case (idx_q[1:0])
			2'd0:    sel_byte = word[31:24];
			2'd1:    sel_byte = word[23:16];
			2'd2:    sel_byte = word[15:8];
			default: sel_byte = word[7:0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (job_pop)
			cur_q <= job;
		if (emit) begin
			out_byte_q <= sel_byte;
			out_last_q <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
				if (last_byte)
					idx_q <= '0;
				else
					idx_q <= idx_q + 1'b1;
			end else if (resp.ready) begin
				out_valid_q <= 1'b0;
			end
			// load the next job right behind the last byte of the current one
			if (job_pop)
				busy_q <= 1'b1;
			else if (emit && last_byte)
				busy_q <= 1'b0;
		end
	end

endmodule

[rtl/ntp_server_response_builder.sv]
// ----------------------------------------------------------------------------
// ntp_server_response_builder
// NTPv4 server/passive reply generator: request bytes in, 48 reply bytes out.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request byte per transfer with req_last on the final byte,
//   plus the current Unix seconds and millisecond, sampled on that final byte.
//   resp carries the 48 reply bytes in order, resp_last on byte 47.
//   cfg_we/cfg_index/cfg_wdata write stratum (index 0) and reference id
//   (index 1); write them only while no reply is pending.
// Path: the final request byte pushes a job into the queue, the serializer loads
//   it into cur_q when free, and the first reply byte leaves the output register.
// Throughput: one request byte per cycle unless the queue is full, one reply
//   byte per cycle while resp.ready is high; the byte counter ends each reply
//   at 48 bytes; a two-entry queue lets the parser run while a reply drains.
// Reset: clears the byte counter, the queue and the serializer; stratum
//   returns to 1 and reference id to "LOCL".
// Stall: resp.ready low holds the output register; the queue fills and then
//   req.ready drops until a job slot frees.
// ----------------------------------------------------------------------------
module ntp_server_response_builder (
	input  logic                                 clk,
	input  logic                                 arst_n,
	ntpsrb_req_if.sink                           req,
	ntpsrb_resp_if.source                        resp,
	input  logic                                 cfg_we,
	input  logic [ntpsrb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ntpsrb_pkg::CFG_W-1:0]         cfg_wdata
);

	ntpsrb_pkg::cfg_t            cfg_q;
	ntpsrb_pkg::job_t            push_job;
	ntpsrb_pkg::job_t            head_job;
	ntpsrb_pkg::fifo_status_t    fifo_st;
	ntpsrb_pkg::back_status_t    back_st;
	logic                        job_push;
	logic                        job_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stratum      <= ntpsrb_pkg::STRATUM_RST;
			cfg_q.reference_id <= ntpsrb_pkg::REF_ID_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ntpsrb_pkg::REG_STRATUM: cfg_q.stratum      <= cfg_wdata[7:0];
				ntpsrb_pkg::REG_REF_ID:  cfg_q.reference_id <= cfg_wdata[31:0];
				default: ;
			endcase
		end
	end

	ntpsrb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.job_full (fifo_st.full),
		.job_push (job_push),
		.job      (push_job)
	);

	ntpsrb_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.wr_job (push_job),
		.pop    (job_pop),
		.rd_job (head_job),
		.status (fifo_st)
	);

	ntpsrb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job_valid (!fifo_st.empty),
		.job       (head_job),
		.job_pop   (job_pop),
		.status    (back_st),
		.resp      (resp)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> !fifo_st.full)
		else $error("job queued while queue full");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> !fifo_st.empty)
		else $error("job taken from empty queue");

	a_idle_idx: assert property (@(posedge clk) disable iff (!arst_n)
		!back_st.busy |-> (back_st.idx == '0))
		else $error("serializer idle with nonzero byte index");

	a_resp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(resp.valid && !resp.ready) |=> (resp.valid && $stable(resp.resp_byte) &&
		$stable(resp.resp_last)))
		else $error("reply byte changed while stalled");

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the NTP server response builder: request bytes go in
// with random pacing, a scoreboard works out the 48-byte reply that each
// request should earn, and every reply byte is compared as it leaves.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          CLK_PERIOD    = 10;
	localparam int          RUN_LIMIT     = 400000;
	localparam int          SETTLE_CYCLES = 8;
	localparam int          NTP_HDR_BYTES = 48;
	localparam logic [31:0] EPOCH_OFFSET  = 32'd2208988800;
	localparam logic [31:0] ZERO_NTP_SECS = 32'd2085978496;
	localparam logic [7:0]  NTP_PRECISION = 8'hFA;
	localparam logic [31:0] ONE_SEC_DISP  = 32'h00010000;
	localparam logic [7:0]  STRATUM_INIT  = 8'd1;
	localparam logic [31:0] REF_ID_INIT   = 32'h4C4F434C;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} reply_byte_t;

	class ntp_reply_scoreboard;
		logic [7:0]  stratum;
		logic [31:0] ref_id;
		int unsigned req_pos;
		logic [2:0]  version;
		logic [2:0]  mode;
		logic [7:0]  poll;
		logic [63:0] origin;
		reply_byte_t reply_bytes[$];
		int unsigned errors;
		int unsigned client_replies;
		int unsigned sym_replies;
		int unsigned silent_requests;
		int unsigned bytes_checked;

		function new();
			stratum = STRATUM_INIT;
			ref_id = REF_ID_INIT;
			req_pos = 0;
			version = '0;
			mode = '0;
			poll = '0;
			origin = '0;
			errors = 0;
			client_replies = 0;
			sym_replies = 0;
			silent_requests = 0;
			bytes_checked = 0;
		endfunction

		function int unsigned pending();
			return reply_bytes.size();
		endfunction

		function void write_reg(logic [ntpsrb_pkg::CFG_IDX_W-1:0] idx,
				logic [ntpsrb_pkg::CFG_W-1:0] data);
			if (idx == ntpsrb_pkg::REG_STRATUM)
				stratum = data[7:0];
			else if (idx == ntpsrb_pkg::REG_REF_ID)
				ref_id = data[31:0];
		endfunction

		// Track one accepted request byte; on the final byte queue the reply if the request qualifies.
		function void note_request(logic [7:0] b, logic last, logic [31:0] secs,
				logic [9:0] ms);
			logic [383:0] reply;
			logic [31:0]  ntp_secs;
			logic [31:0]  frac;
			logic [31:0]  disp;
			logic [63:0]  ms64;
			logic [2:0]   resp_mode;
			reply_byte_t  rb;
			bit           full;

			if (req_pos == 0) begin
				version = b[5:3];
				mode = b[2:0];
			end
			if (req_pos == 2)
				poll = b;
			if (req_pos >= 40 && req_pos < NTP_HDR_BYTES)
				origin = {origin[55:0], b};
			if (req_pos < NTP_HDR_BYTES)
				req_pos++;
			if (!last)
				return;

			full = (req_pos >= NTP_HDR_BYTES);
			req_pos = 0;
			if (!full || secs == 32'd0 || !(mode == ntpsrb_pkg::MODE_CLIENT ||
				mode == ntpsrb_pkg::MODE_SYM_ACTIVE)) begin
				silent_requests++;
				return;
			end
			if (mode == ntpsrb_pkg::MODE_CLIENT) begin
				resp_mode = ntpsrb_pkg::MODE_SERVER;
				client_replies++;
			end else begin
				resp_mode = ntpsrb_pkg::MODE_SYM_PASSIVE;
				sym_replies++;
			end

			ntp_secs = secs + EPOCH_OFFSET;
			ms64 = 64'(ms) % 64'd1000;
			frac = 32'((ms64 << 32) / 64'd1000);
			disp = (stratum != STRATUM_INIT) ? ONE_SEC_DISP : 32'd0;
			reply = {2'b00, version, resp_mode, stratum, poll, NTP_PRECISION,
				32'd0, disp, ref_id, ntp_secs, frac, origin,
				ntp_secs, frac, ntp_secs, frac};
			for (int k = 0; k < NTP_HDR_BYTES; k++) begin
				rb.data = reply[383 - 8 * k -: 8];
				rb.last = (k == NTP_HDR_BYTES - 1);
				reply_bytes.push_back(rb);
			end
		endfunction

		function void check_reply(logic [7:0] b, logic last);
			reply_byte_t exp_b;

			if (reply_bytes.size() == 0) begin
				errors++;
				$display("%0t: unexpected reply byte %02h last %0b", $time, b, last);
				return;
			end
			exp_b = reply_bytes.pop_front();
			bytes_checked++;
			if (b !== exp_b.data) begin
				errors++;
				$display("%0t: resp_byte mismatch: expected %02h, got %02h",
					$time, exp_b.data, b);
			end
			if (last !== exp_b.last) begin
				errors++;
				$display("%0t: resp_last mismatch: expected %0b, got %0b",
					$time, exp_b.last, last);
			end
		endfunction
	endclass

	logic                             clk = 1'b0;
	logic                             arst_n;
	logic                             cfg_we;
	logic [ntpsrb_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [ntpsrb_pkg::CFG_W-1:0]     cfg_wdata;

	ntpsrb_req_if  req_ch();
	ntpsrb_resp_if resp_ch();

	ntp_reply_scoreboard sb = new();

	bit          idle_on;
	int          rx_hold_cycles;
	int unsigned bytes_sent;
	int unsigned cycle_count;

	ntp_server_response_builder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.resp      (resp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("%0t: timeout with %0d reply bytes outstanding", $time, sb.pending());
			$display("tb: failure");
			$finish;
		end
	end

	// mostly back-to-back, sometimes a short pause, now and then a long one
	function automatic int pick_gap();
		int r;

		r = $urandom_range(99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// reply side: random backpressure, plus one long hold-off on request
	initial begin : reply_sink
		int gap_left;

		gap_left = 0;
		resp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && resp_ch.valid === 1'b1 && resp_ch.ready === 1'b1)
				sb.check_reply(resp_ch.resp_byte, resp_ch.resp_last);
			if (rx_hold_cycles > 0) begin
				resp_ch.ready <= 1'b0;
				rx_hold_cycles--;
			end else if (!idle_on) begin
				resp_ch.ready <= 1'b1;
			end else if (gap_left > 0) begin
				resp_ch.ready <= 1'b0;
				gap_left--;
			end else begin
				resp_ch.ready <= 1'b1;
				gap_left = pick_gap();
			end
		end
	end

	task automatic offer_request_byte(input logic [7:0] b, input logic last,
			input logic [31:0] secs, input logic [9:0] ms);
		int gap;

		gap = idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_byte <= b;
		req_ch.req_last <= last;
		req_ch.now_unix_secs <= secs;
		req_ch.now_millis <= ms;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		sb.note_request(b, last, secs, ms);
		bytes_sent++;
	endtask

	// fill < 0 means random body bytes; time is only meaningful on the last byte
	task automatic send_ntp_request(input int len, input logic [7:0] first, input int fill,
			input logic [31:0] secs, input logic [9:0] ms);
		logic [7:0] b;

		for (int i = 0; i < len; i++) begin
			if (i == 0)
				b = first;
			else if (fill < 0)
				b = 8'($urandom);
			else
				b = fill[7:0];
			if (i == len - 1)
				offer_request_byte(b, 1'b1, secs, ms);
			else
				offer_request_byte(b, 1'b0, $urandom, 10'($urandom));
		end
	endtask

	task automatic send_random_request(input bit well_formed);
		int          len;
		logic [7:0]  first;
		logic [31:0] secs;
		logic [9:0]  ms;
		int          pick;

		len = NTP_HDR_BYTES;
		first = 8'($urandom);
		first[2:0] = $urandom_range(1) ? ntpsrb_pkg::MODE_CLIENT :
			ntpsrb_pkg::MODE_SYM_ACTIVE;

		pick = $urandom_range(9);
		if (pick == 0)
			secs = '1;
		else if (pick == 1)
			secs = ZERO_NTP_SECS + 32'($urandom_range(2)) - 32'd1;
		else
			secs = $urandom;
		if (secs == 32'd0)
			secs = 32'd1;

		pick = $urandom_range(9);
		if (pick < 8)
			ms = 10'($urandom_range(999));
		else if (pick == 8)
			ms = $urandom_range(1) ? 10'd999 : 10'd0;
		else
			ms = 10'($urandom_range(1000, 1023));

		if (!well_formed && $urandom_range(99) < 35) begin
			case ($urandom_range(3))
				0: len = $urandom_range(1, NTP_HDR_BYTES - 1);
				1: len = $urandom_range(NTP_HDR_BYTES + 1, NTP_HDR_BYTES + 12);
				2: begin
					do first[2:0] = 3'($urandom);
					while (first[2:0] == ntpsrb_pkg::MODE_CLIENT ||
						first[2:0] == ntpsrb_pkg::MODE_SYM_ACTIVE);
				end
				default: secs = '0;
			endcase
		end
		send_ntp_request(len, first, -1, secs, ms);
	endtask

	task automatic run_random_phase(input int unsigned n_bytes, input int unsigned n_good);
		int unsigned stop_at;
		int unsigned reqs;

		stop_at = bytes_sent + n_bytes;
		reqs = 0;
		while (bytes_sent < stop_at) begin
			send_random_request(reqs < n_good);
			reqs++;
		end
	endtask

	// hold until every reply byte is out, then let the parser settle
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_config(input logic [7:0] stratum, input logic [31:0] ref_id);
		logic [ntpsrb_pkg::CFG_W-1:0] data;

		// junk in the upper bits must not reach the stratum register
		data = {24'($urandom), stratum};
		cfg_we <= 1'b1;
		cfg_index <= ntpsrb_pkg::REG_STRATUM;
		cfg_wdata <= data;
		@(posedge clk);
		sb.write_reg(ntpsrb_pkg::REG_STRATUM, data);
		cfg_index <= ntpsrb_pkg::REG_REF_ID;
		cfg_wdata <= ref_id;
		@(posedge clk);
		sb.write_reg(ntpsrb_pkg::REG_REF_ID, ref_id);
		cfg_we <= 1'b0;
	endtask

	task automatic set_pacing(input bit idle, input int hold);
		@(negedge clk);
		idle_on = idle;
		rx_hold_cycles = hold;
		@(posedge clk);
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_byte = '0;
		req_ch.req_last = 1'b0;
		req_ch.now_unix_secs = '0;
		req_ch.now_millis = '0;
		cfg_we = 1'b0;
		cfg_index = ntpsrb_pkg::REG_STRATUM;
		cfg_wdata = '0;
		idle_on = 1'b1;
		rx_hold_cycles = 0;
		bytes_sent = 0;
		cycle_count = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed requests under the reset configuration
		send_ntp_request(1, {2'b11, 3'd4, ntpsrb_pkg::MODE_CLIENT}, -1, 32'd1, 10'd0);
		send_ntp_request(NTP_HDR_BYTES, {2'b11, 3'd4, ntpsrb_pkg::MODE_CLIENT}, 8'hFF,
			'1, 10'd999);
		send_ntp_request(NTP_HDR_BYTES + 2, {2'b00, 3'd3, ntpsrb_pkg::MODE_CLIENT}, -1,
			32'd0, 10'd500);
		send_ntp_request(NTP_HDR_BYTES - 1, {2'b00, 3'd4, ntpsrb_pkg::MODE_CLIENT}, -1,
			32'd7, 10'd0);
		send_ntp_request(NTP_HDR_BYTES, {2'b00, 3'd4, ntpsrb_pkg::MODE_SERVER}, -1,
			32'd5, 10'd1);
		send_ntp_request(NTP_HDR_BYTES + 5, {2'b00, 3'd3, ntpsrb_pkg::MODE_CLIENT}, -1,
			ZERO_NTP_SECS, 10'd1023);
		drain();

		// receiver stalls long while full requests keep coming: the job queue fills
		write_config(8'd255, $urandom);
		set_pacing(1'b0, 600);
		run_random_phase(150, 4);
		drain();

		$display("summary: %0d request bytes sent, %0d reply bytes checked",
			bytes_sent, sb.bytes_checked);
		$display("summary: %0d client and %0d symmetric active replies, %0d requests dropped",
			sb.client_replies, sb.sym_replies, sb.silent_requests);
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

[sim.f]
rtl/ntpsrb_pkg.sv
rtl/ntpsrb_req_if.sv
rtl/ntpsrb_resp_if.sv
rtl/ntpsrb_front.sv
rtl/ntpsrb_fifo.sv
rtl/ntpsrb_back.sv
rtl/ntp_server_response_builder.sv
verif/testbench.sv
